@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion forms used by the port checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_ON_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/modexp_pkg.sv @@
// ----------------------------------------------------------------------------
// modexp package
// shared types and constants of the modular exponentiation block
// ----------------------------------------------------------------------------
`default_nettype none

package modexp_pkg;

  // width of the data and config ports
  localparam int FIELD_BITS = 32;
  localparam int CFG_IDX_BITS = 1;

  // config register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_EXPONENT = 1'b1;

  // status of one serial modular multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/modexp_mulmod.sv @@
// ----------------------------------------------------------------------------
// modexp serial modular multiplier
// interleaved multiply and reduce, one multiplier bit per cycle, msb first
// ----------------------------------------------------------------------------
`default_nettype none

module modexp_mulmod #(
  parameter int W = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [W-1:0]         op_a,   // addend, below op_m
  input  logic [W-1:0]         op_b,   // multiplier, any value
  input  logic [W-1:0]         op_m,
  output logic [W-1:0]         prod,
  output modexp_pkg::mm_stat_t stat
);
  import modexp_pkg::*;

  localparam int CW = $clog2(W);

  logic [W-1:0]  part_r, part_nxt;
  logic [W-1:0]  mplr_r, mplr_nxt;
  logic [W-1:0]  add_r, add_nxt;
  logic [W-1:0]  mod_r, mod_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  logic [W+1:0]  sum, m1, m2, d1, d2;
  logic [W-1:0]  red;

  // 2r + bit*a stays below 3m, so at most two subtractions of m
  always_comb begin
    sum = (W+2)'({part_r, 1'b0}) + (mplr_r[W-1] ? (W+2)'(add_r) : '0);
    m1  = (W+2)'(mod_r);
    m2  = (W+2)'({mod_r, 1'b0});
    d1  = sum - m1;
    d2  = sum - m2;
    priority if (sum >= m2) begin
      red = d2[W-1:0];
    end else if (sum >= m1) begin
      red = d1[W-1:0];
    end else begin
      red = sum[W-1:0];
    end
  end

  always_comb begin
    part_nxt = part_r;
    mplr_nxt = mplr_r;
    add_nxt  = add_r;
    mod_nxt  = mod_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      part_nxt = '0;
      mplr_nxt = op_b;
      add_nxt  = op_a;
      mod_nxt  = op_m;
      cnt_nxt  = CW'(W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      part_nxt = red;
      mplr_nxt = {mplr_r[W-2:0], 1'b0};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    part_r <= part_nxt;
    mplr_r <= mplr_nxt;
    add_r  <= add_nxt;
    mod_r  <= mod_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign prod      = part_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

@@ hw/rtl/modular_exponentiation.sv @@
// timing: the time from input transfer to result valid grows with k, the position
//   of the highest set exponent bit plus one, as one step runs per exponent bit
// flow: one item at a time, with no new input transfer until the result has moved
//   to the output register; the step time is set by the bit-serial multipliers
// reset (synchronous, rst_n low): modulus 2, exponent 0, no result pending
// ----------------------------------------------------------------------------
// modular exponentiation top level
// right-to-left square-and-multiply over two bit-serial modular multipliers
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation #(
  parameter int WORD_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [modexp_pkg::FIELD_BITS-1:0]   in_ciphertext,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [modexp_pkg::FIELD_BITS-1:0]   out_plaintext,
  // config write port
  input  logic                                cfg_we,
  input  logic [modexp_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [modexp_pkg::FIELD_BITS-1:0]   cfg_wdata
);
  import modexp_pkg::*;

  localparam int W = WORD_BITS;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,  // waiting for a ciphertext transfer
    S_REDUCE = 4'b0010,  // base = ciphertext mod modulus
    S_STEP   = 4'b0100,  // one exponent bit: multiply and square in parallel
    S_OUT    = 4'b1000   // result waits for the output register
  } state_t;

  state_t state_r, state_nxt;

  // config registers, kept at full port width
  logic [FIELD_BITS-1:0] mod_cfg_r, exp_cfg_r;

  // working registers
  logic [W-1:0] exp_r, exp_nxt;      // exponent, shifted right one bit per step
  logic [W-1:0] acc_r, acc_nxt;      // running product
  logic [W-1:0] base_r, base_nxt;    // base, squared each step
  logic [W-1:0] res_r, res_nxt;      // finished result

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [FIELD_BITS-1:0] out_data_r, out_data_nxt;

  // only the low WORD_BITS bits of every operand take part
  logic [W-1:0] mod_w, exp_w, ctext_w;

  // multiplier hookup: unit 0 does acc*base (and the first reduction),
  // unit 1 squares the base
  logic         start0, start1;
  logic [W-1:0] a0, b0, a1, b1, prod0, prod1;
  mm_stat_t     stat0, stat1;

  logic [W-1:0] acc_new, base_new, exp_shift;
  logic         in_xfer;

  assign mod_w   = mod_cfg_r[W-1:0];
  assign exp_w   = exp_cfg_r[W-1:0];
  assign ctext_w = in_ciphertext[W-1:0];

  assign in_ready = (state_r == S_IDLE) && !stat0.busy && !stat1.busy;
  assign in_xfer  = in_valid && in_ready;

  // values after one exponent step
  assign acc_new   = exp_r[0] ? prod0 : acc_r;
  assign base_new  = prod1;
  assign exp_shift = exp_r >> 1;

  always_comb begin
    state_nxt     = state_r;
    exp_nxt       = exp_r;
    acc_nxt       = acc_r;
    base_nxt      = base_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    start0        = 1'b0;
    start1        = 1'b0;
    a0            = acc_r;
    b0            = base_r;
    a1            = base_r;
    b1            = base_r;

    // result taken downstream
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          priority if (mod_w < W'(2)) begin
            // everything is zero modulo one, and modulus zero gives zero too
            res_nxt   = '0;
            state_nxt = S_OUT;
          end else if (exp_w == '0) begin
            res_nxt   = W'(1);
            state_nxt = S_OUT;
          end else begin
            // ciphertext mod m as 1 * ciphertext through unit 0
            start0    = 1'b1;
            a0        = W'(1);
            b0        = ctext_w;
            exp_nxt   = exp_w;
            acc_nxt   = W'(1);
            state_nxt = S_REDUCE;
          end
        end
      end
      S_REDUCE: begin
        if (stat0.done) begin
          base_nxt  = prod0;
          start0    = 1'b1;
          start1    = 1'b1;
          a0        = acc_r;
          b0        = prod0;
          a1        = prod0;
          b1        = prod0;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        // both units start together and finish in the same cycle
        if (stat0.done && stat1.done) begin
          acc_nxt  = acc_new;
          base_nxt = base_new;
          exp_nxt  = exp_shift;
          if (exp_shift == '0) begin
            // no set bits left, further squares change nothing
            res_nxt   = acc_new;
            state_nxt = S_OUT;
          end else begin
            start0    = 1'b1;
            start1    = 1'b1;
            a0        = acc_new;
            b0        = base_new;
            a1        = base_new;
            b1        = base_new;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = FIELD_BITS'(res_r);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  modexp_mulmod #(
    .W (W)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start0),
    .op_a  (a0),
    .op_b  (b0),
    .op_m  (mod_w),
    .prod  (prod0),
    .stat  (stat0)
  );

  modexp_mulmod #(
    .W (W)
  ) u_sqr (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start1),
    .op_a  (a1),
    .op_b  (b1),
    .op_m  (mod_w),
    .prod  (prod1),
    .stat  (stat1)
  );

  // control state and config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mod_cfg_r   <= FIELD_BITS'(2);
      exp_cfg_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MODULUS:  mod_cfg_r <= cfg_wdata;
          REG_EXPONENT: exp_cfg_r <= cfg_wdata;
          default:      ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    exp_r      <= exp_nxt;
    acc_r      <= acc_nxt;
    base_r     <= base_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_plaintext = out_data_r;

endmodule

`default_nettype wire

@@ hw/rtl/modexp_checker.sv @@
// ----------------------------------------------------------------------------
// modexp port checker
// port-level checks of the modular exponentiation block, bound to the top
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module modexp_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [modexp_pkg::FIELD_BITS-1:0]   out_plaintext
);
  import modexp_pkg::*;

  // a pending result stays until its transfer
  `ASSERT_ON_RST(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped")
  `ASSERT_ON_RST(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_plaintext), "result moved")
  // one item at a time: no new input right after a transfer
  `ASSERT_ON_RST(a_one_item, clk, rst_n, in_valid && in_ready |=> !in_ready, "input while busy")
  // reset leaves the block empty and ready
  `ASSERT_ALWAYS(a_reset_state, clk, !rst_n |=> !out_valid && in_ready, "bad state after reset")

endmodule

bind modular_exponentiation modexp_checker u_modexp_checker (.*);

`default_nettype wire

@@ bench/modexp_checker.sv @@
// ----------------------------------------------------------------------------
// modexp checker
// follows the key writes, computes the expected plaintext of every
// ciphertext transfer and compares it with the result transfers in order
// ----------------------------------------------------------------------------
`default_nettype none

module modexp_scoreboard #(
  parameter int WORD_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [modexp_pkg::FIELD_BITS-1:0]   in_ciphertext,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [modexp_pkg::FIELD_BITS-1:0]   out_plaintext,
  input  logic                                cfg_we,
  input  logic [modexp_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [modexp_pkg::FIELD_BITS-1:0]   cfg_wdata,
  output int                                  pending,
  output int                                  failures
);

  import modexp_pkg::*;

  typedef logic [FIELD_BITS-1:0] word_t;

  localparam logic [63:0] WORD_MASK = (64'd1 << WORD_BITS) - 64'd1;

  word_t key_modulus;
  word_t key_exponent;
  word_t plaintext_due[$];

  // right-to-left square-and-multiply, products kept in 64 bits
  function automatic word_t power_mod(word_t ciphertext, word_t modulus_w, word_t exponent_w);
    logic [63:0] base;
    logic [63:0] acc;
    logic [63:0] m;
    logic [63:0] e;
    m = {32'd0, modulus_w} & WORD_MASK;
    e = {32'd0, exponent_w} & WORD_MASK;
    if (m < 64'd2) return '0;
    base = ({32'd0, ciphertext} & WORD_MASK) % m;
    acc = 64'd1;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (e[0]) acc = (acc * base) % m;
      base = (base * base) % m;
      e = e >> 1;
    end
    return word_t'(acc);
  endfunction

  always @(posedge clk) begin
    word_t want;
    if (!rst_n) begin
      key_modulus = word_t'(2);
      key_exponent = '0;
      plaintext_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (plaintext_due.size() == 0) begin
          failures++;
          $error("plaintext: result transfer with nothing expected, got 0x%08h", out_plaintext);
        end else begin
          want = plaintext_due.pop_front();
          if (out_plaintext !== want) begin
            failures++;
            $error("plaintext mismatch: expected 0x%08h, got 0x%08h", want, out_plaintext);
          end
        end
      end
      // the key in use is the one held before this edge
      if (in_valid && in_ready)
        plaintext_due.insert(plaintext_due.size(),
                             power_mod(in_ciphertext, key_modulus, key_exponent));
      if (cfg_we) begin
        case (cfg_index)
          REG_MODULUS:  key_modulus = cfg_wdata;
          REG_EXPONENT: key_exponent = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending = plaintext_due.size();
  end

endmodule

`default_nettype wire

@@ bench/modular_exponentiation_test.sv @@
// ----------------------------------------------------------------------------
// modular exponentiation testbench
// drives ciphertext words under a series of keys, directed corner keys first
// and then random keys and words, with random stalls on both channels;
// the checker beside the block predicts and compares every plaintext
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation_test;

  import modexp_pkg::*;

  typedef logic [FIELD_BITS-1:0] word_t;

  localparam int WORD_BITS      = 32;
  // limit above the longest item plus a receiver stall
  localparam int WATCHDOG_LIMIT = 10000;
  // quiet time after the last plaintext
  localparam int TAIL_CYCLES    = 1100;
  localparam int RANDOM_ITEMS   = 275;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  word_t                   in_ciphertext = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  word_t                   out_plaintext;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = REG_MODULUS;
  word_t                   cfg_wdata = '0;

  int    pending;
  int    failures;
  int    stall_left = 0;
  int    idle_cycles = 0;
  bit    idling_on = 1'b1;
  word_t cur_modulus = word_t'(2);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  modular_exponentiation #(
    .WORD_BITS(WORD_BITS)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_ciphertext (in_ciphertext),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_plaintext (out_plaintext),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  modexp_scoreboard #(
    .WORD_BITS(WORD_BITS)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_ciphertext (in_ciphertext),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_plaintext (out_plaintext),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .pending       (pending),
    .failures      (failures)
  );

  // receiver: ready drops for random bursts while idling is on
  always @(posedge clk) begin
    if (stall_left > 1) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      out_ready <= 1'b1;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog: any transfer on either channel restarts the count
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one ciphertext transfer; valid stays high after it so that a following
  // word goes out back to back, an idle gap lowers it first
  task automatic send_ciphertext(input word_t c);
    int gap;
    if (idling_on && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ciphertext <= c;
    do @(posedge clk); while (!in_ready);
  endtask

  // called in the step of the last transfer; returns on a rising edge once
  // every plaintext has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // both key registers, back to back, only while the block is idle
  task automatic load_key(input word_t m, input word_t e);
    cfg_we <= 1'b1;
    cfg_index <= REG_MODULUS;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_index <= REG_EXPONENT;
    cfg_wdata <= e;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_modulus = m;
  endtask

  function automatic word_t pick_modulus();
    word_t m;
    case ($urandom_range(0, 7))
      0: m = word_t'($urandom_range(2, 255));
      1: m = word_t'($urandom_range(256, 65535));
      2, 3: m = $urandom | 32'h8000_0000;
      4: m = 32'hFFFF_FFFF;
      default: m = $urandom >> $urandom_range(0, 29);
    endcase
    if (m < 2) m = word_t'(2);
    return m;
  endfunction

  // short exponents are favored to keep the run short, full ones still common
  function automatic word_t pick_exponent();
    case ($urandom_range(0, 5))
      0: return word_t'($urandom_range(0, 15));
      1, 2: return $urandom >> $urandom_range(8, 31);
      3: return $urandom >> $urandom_range(0, 31);
      4: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic word_t pick_ciphertext();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return word_t'(1);
      2: return cur_modulus - word_t'(1);
      3: return cur_modulus;
      4: return '1;
      5, 6: return $urandom % cur_modulus;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int sent;
    int batch;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset key: modulus 2, exponent 0, so every plaintext is one
    send_ciphertext('0);
    send_ciphertext('1);
    wait_drained();

    // widest modulus and exponent, extreme and alternating words
    load_key(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_ciphertext('0);
    send_ciphertext(word_t'(1));
    send_ciphertext(32'hFFFF_FFFF);
    send_ciphertext(32'hFFFF_FFFE);
    send_ciphertext(32'h8000_0000);
    send_ciphertext(32'h5555_5555);
    send_ciphertext(32'hAAAA_AAAA);
    wait_drained();

    // modulus one gives zero, zero exponent included
    load_key(word_t'(1), '0);
    send_ciphertext(word_t'(5));
    wait_drained();
    load_key(word_t'(1), 32'hFFFF_FFFF);
    send_ciphertext(32'hFFFF_FFFF);
    wait_drained();

    // modulus zero gives zero without a division
    load_key('0, 32'h0001_2345);
    send_ciphertext(word_t'(7));
    wait_drained();

    // smallest modulus, exponent one
    load_key(word_t'(2), word_t'(1));
    send_ciphertext(word_t'(3));
    send_ciphertext(word_t'(2));
    wait_drained();

    // zero exponent under a large prime modulus, zero base too
    load_key(32'hFFFF_FFFB, '0);
    send_ciphertext('0);
    send_ciphertext(32'hFFFF_FFFB);
    wait_drained();

    // small textbook key
    load_key(word_t'(3233), word_t'(2753));
    send_ciphertext(word_t'(2790));
    send_ciphertext(word_t'(65));
    wait_drained();

    // random keys, a batch of random words under each; no idling at the end
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      batch = $urandom_range(8, 30);
      if (batch > RANDOM_ITEMS - sent) batch = RANDOM_ITEMS - sent;
      if (RANDOM_ITEMS - sent <= 40)
        idling_on = 1'b0;
      else
        idling_on = ($urandom_range(0, 3) != 0);
      load_key(pick_modulus(), pick_exponent());
      repeat (batch) send_ciphertext(pick_ciphertext());
      sent += batch;
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
